>>> src/skst_pkg.sv
// Package for the sorted key set: widths, result codes, controller states
// and the command/status bundles between the controller and the datapath.
// No dependencies.
package skst_pkg;

    localparam int KEY_W        = 32;
    localparam int OUT_CNT_W    = 7;
    localparam int DEF_CAPACITY = 64;

    // result status codes
    typedef enum logic [1:0] {
        RES_QUERIED = 2'd0,
        RES_ADDED   = 2'd1,
        RES_REMOVED = 2'd2,
        RES_REFUSED = 2'd3
    } res_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_CHECK,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic      start;     // latch item, open the search window
        logic      srch_cmp;  // narrow the search window
        logic      check;     // latch membership of the key
        logic      dn_init;   // arm the close-gap shift
        logic      up_init;   // arm the open-gap shift
        logic      shift_dn;  // stream entries one slot down
        logic      shift_up;  // stream entries one slot up
        logic      finish;    // update count, load result
        res_code_t code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic toggle;       // latched command is a toggle
        logic search_open;  // lo < hi
        logic present;      // key found at lower bound (valid in S_CHECK)
        logic full;         // set holds CAPACITY keys
        logic dn_busy;      // close-gap shift still moving data
        logic up_busy;      // open-gap shift still moving data
        logic out_busy;     // result register holds an untaken result
    } stat_t;

endpackage

>>> src/sorted_key_set_toggle_top.sv
// Top level of the sorted key set with query and toggle commands.
// Instantiates skst_ctrl and skst_dp; depends on skst_pkg.
//
//   channel   direction  ports                                     meaning
//   s_        in         s_command, s_key                          query / toggle a key
//   m_        out        m_was_present, m_now_member, m_status,    one result per item
//                        m_entry_count
//
// One item at a time. Search: each halving of the window takes a memory read
// state, then a compare state, and the membership check follows the search.
// A remove or insert then streams the m keys above the slot one per cycle (one
// read and one write a cycle on the key memory), and the finish step loads the result.
// Reset clears the count and the handshake; key memory is not cleared.
// A stalled result holds in the output register; the next item is already
// taken and waits only at its finish step for the register to drain.
module sorted_key_set_toggle_top #(
    parameter int CAPACITY = skst_pkg::DEF_CAPACITY
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [skst_pkg::KEY_W-1:0]      s_key,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_was_present,
    output logic                            m_now_member,
    output logic [1:0]                      m_status,
    output logic [skst_pkg::OUT_CNT_W-1:0]  m_entry_count
);
    import skst_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: accepts a transfer in idle, steps search and shift
    skst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // key memory, window registers, count and result register
    skst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_command     (s_command),
        .s_key         (s_key),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_was_present (m_was_present),
        .m_now_member  (m_now_member),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

endmodule

>>> src/skst_ctrl.sv
// Sequencer for the sorted key set: search, membership check, shift, finish.
// Depends on skst_pkg.
module skst_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  skst_pkg::stat_t  stat,
    output skst_pkg::cmd_t   cmd
);
    import skst_pkg::*;

    state_t    state_reg, state_next;
    res_code_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= RES_QUERIED;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                // read of mid (or of lo once the window is closed) in flight
                state_next = stat.search_open ? S_SRCH_CMP : S_CHECK;
            end
            S_SRCH_CMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH_RD;
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (!stat.toggle) begin
                    code_next  = RES_QUERIED;
                    state_next = S_FINISH;
                end else if (stat.present) begin
                    cmd.dn_init = 1'b1;
                    code_next   = RES_REMOVED;
                    state_next  = S_SHIFT_DN;
                end else if (stat.full) begin
                    code_next  = RES_REFUSED;
                    state_next = S_FINISH;
                end else begin
                    cmd.up_init = 1'b1;
                    code_next   = RES_ADDED;
                    state_next  = S_SHIFT_UP;
                end
            end
            S_SHIFT_DN: begin
                cmd.shift_dn = 1'b1;
                if (!stat.dn_busy) begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP: begin
                cmd.shift_up = 1'b1;
                if (!stat.up_busy) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/skst_dp.sv
// Datapath for the sorted key set: key memory, search window, shift pointers,
// entry count and result register. Depends on skst_pkg.
module skst_dp #(
    parameter int CAPACITY = skst_pkg::DEF_CAPACITY
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_command,
    input  logic [skst_pkg::KEY_W-1:0]      s_key,
    input  skst_pkg::cmd_t                  cmd,
    output skst_pkg::stat_t                 stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_was_present,
    output logic                            m_now_member,
    output logic [1:0]                      m_status,
    output logic [skst_pkg::OUT_CNT_W-1:0]  m_entry_count
);
    import skst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    logic             toggle_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CW-1:0]    lo_reg, hi_reg, count_reg, ptr_reg;
    logic             found_reg;
    logic             pend_reg;
    logic [AW-1:0]    wa_reg;
    logic [CW-1:0]    mid;
    logic             present;
    logic             dn_issue, up_issue;

    logic             m_valid_reg;
    logic             was_reg, now_reg;
    logic [1:0]       status_reg;
    logic [OUT_CNT_W-1:0] ecount_reg;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign present  = (lo_reg < count_reg) && (rd_data_reg == key_reg);
    assign dn_issue = ptr_reg < count_reg;
    assign up_issue = ptr_reg > lo_reg;

    always_comb begin
        if (cmd.shift_dn) begin
            rd_addr = AW'(ptr_reg);
        end else if (cmd.shift_up) begin
            rd_addr = AW'(ptr_reg - CW'(1));
        end else if (lo_reg < hi_reg) begin
            rd_addr = AW'(mid);
        end else begin
            rd_addr = AW'(lo_reg);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = wa_reg;
        wr_data = rd_data_reg;
        if ((cmd.shift_dn || cmd.shift_up) && pend_reg) begin
            wr_en = 1'b1;
        end else if (cmd.finish && cmd.code == RES_ADDED) begin
            wr_en   = 1'b1;
            wr_addr = AW'(lo_reg);
            wr_data = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= key_mem[rd_addr];
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
    end

    // search window, pointers and latched item
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            toggle_reg <= s_command;
            key_reg    <= s_key;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
        end
        if (cmd.srch_cmp) begin
            if (rd_data_reg < key_reg) begin
                lo_reg <= mid + CW'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.check) begin
            found_reg <= present;
        end
        if (cmd.dn_init) begin
            ptr_reg <= lo_reg + CW'(1);
        end else if (cmd.up_init) begin
            ptr_reg <= count_reg;
        end else if (cmd.shift_dn && dn_issue) begin
            ptr_reg <= ptr_reg + CW'(1);
            wa_reg  <= AW'(ptr_reg - CW'(1));
        end else if (cmd.shift_up && up_issue) begin
            ptr_reg <= ptr_reg - CW'(1);
            wa_reg  <= AW'(ptr_reg);
        end
    end

    // control state: count, in-flight read flag, result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.dn_init || cmd.up_init) begin
                pend_reg <= 1'b0;
            end else if (cmd.shift_dn) begin
                pend_reg <= dn_issue;
            end else if (cmd.shift_up) begin
                pend_reg <= up_issue;
            end
            if (cmd.finish && cmd.code == RES_ADDED) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.finish && cmd.code == RES_REMOVED) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            was_reg    <= found_reg;
            now_reg    <= (cmd.code == RES_ADDED) ||
                          (cmd.code == RES_QUERIED && found_reg);
            status_reg <= cmd.code;
            case (cmd.code)
                RES_ADDED:   ecount_reg <= OUT_CNT_W'(count_reg + CW'(1));
                RES_REMOVED: ecount_reg <= OUT_CNT_W'(count_reg - CW'(1));
                default:     ecount_reg <= OUT_CNT_W'(count_reg);
            endcase
        end
    end

    assign stat.toggle      = toggle_reg;
    assign stat.search_open = lo_reg < hi_reg;
    assign stat.present     = present;
    assign stat.full        = count_reg == CW'(CAPACITY);
    assign stat.dn_busy     = dn_issue || pend_reg;
    assign stat.up_busy     = up_issue || pend_reg;
    assign stat.out_busy    = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_was_present = was_reg;
    assign m_now_member  = now_reg;
    assign m_status      = status_reg;
    assign m_entry_count = ecount_reg;

endmodule
